// File: rtl/fta_pkg.sv
// Shared widths, constants and the lane result type of the fault time accumulator.
package fta_pkg;

    localparam int MAX_CH    = 8;
    localparam int TICK_W    = 32;
    localparam int TMO_W     = 31;
    localparam int CODE_W    = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(1000);

    typedef struct packed {
        logic              fired;
        logic              raised;
        logic [CODE_W-1:0] held;
    } lane_res_t;

endpackage

// File: rtl/fta_lane.sv
// One channel of the leaky-bucket accumulator: fault time, raised flag and latched code.
module fta_lane (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        upd,
    input  logic [fta_pkg::TICK_W-1:0]  elapsed,
    input  logic [fta_pkg::CODE_W-1:0]  code,
    input  logic [fta_pkg::TMO_W-1:0]   timeout,
    output fta_pkg::lane_res_t          res
);
    import fta_pkg::*;

    logic [TMO_W-1:0]  fault_time_reg, fault_time_next;
    logic              raised_reg;
    logic [CODE_W-1:0] held_reg;

    logic [TMO_W+1:0]  sum;
    logic [TMO_W+1:0]  tmo_ext;
    logic [TMO_W+1:0]  half_ext;
    logic [TMO_W-1:0]  half;
    logic              acc_gt;
    logic [TMO_W-1:0]  acc_dec;
    logic              fire;
    logic              clr;

    assign half     = timeout >> 1;
    assign tmo_ext  = {2'b00, timeout};
    assign half_ext = {2'b00, half};
    assign sum      = {2'b00, fault_time_reg} + {1'b0, elapsed};
    assign acc_gt   = {1'b0, fault_time_reg} > elapsed;
    assign acc_dec  = acc_gt ? (fault_time_reg - elapsed[TMO_W-1:0]) : '0;

    always_comb
    begin
        if (code != '0)
        begin
            // add and clamp at the timeout
            fault_time_next = (sum > tmo_ext) ? timeout : sum[TMO_W-1:0];
            fire            = (sum >= tmo_ext);
            clr             = (sum <= half_ext);
        end
        else
        begin
            // drain toward zero
            fault_time_next = acc_dec;
            fire            = (acc_dec >= timeout);
            clr             = (acc_dec <= half);
        end

        res.fired = fire;
        if (fire)
        begin
            res.raised = 1'b1;
            res.held   = code;
        end
        else if (clr)
        begin
            res.raised = 1'b0;
            res.held   = '0;
        end
        else
        begin
            res.raised = raised_reg;
            res.held   = held_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_time_reg <= '0;
            raised_reg     <= 1'b0;
            held_reg       <= '0;
        end
        else if (upd)
        begin
            fault_time_reg <= fault_time_next;
            raised_reg     <= res.raised;
            held_reg       <= res.held;
        end
    end

endmodule

// File: rtl/fta_merge.sv
// Merge of the lane results into the registered result item.
module fta_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        out_ready,
    input  fta_pkg::lane_res_t          res [fta_pkg::MAX_CH],
    output logic                        out_valid,
    output logic                        any_fired,
    output logic [fta_pkg::MAX_CH-1:0]  fired_mask,
    output logic [fta_pkg::MAX_CH-1:0]  raised_mask,
    output logic [fta_pkg::CODE_W-1:0]  latched [fta_pkg::MAX_CH]
);
    import fta_pkg::*;

    logic              out_valid_reg;
    logic [MAX_CH-1:0] fired_mask_reg;
    logic [MAX_CH-1:0] raised_mask_reg;
    logic              any_fired_reg;
    logic [CODE_W-1:0] latched_reg [MAX_CH];

    logic [MAX_CH-1:0] fired_next;
    logic [MAX_CH-1:0] raised_next;

    always_comb
    begin
        for (int c = 0; c < MAX_CH; c++)
        begin
            fired_next[c]  = res[c].fired;
            raised_next[c] = res[c].raised;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fired_mask_reg  <= fired_next;
            raised_mask_reg <= raised_next;
            any_fired_reg   <= |fired_next;
            for (int c = 0; c < MAX_CH; c++)
            begin
                latched_reg[c] <= res[c].held;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign any_fired   = any_fired_reg;
    assign fired_mask  = fired_mask_reg;
    assign raised_mask = raised_mask_reg;
    assign latched     = latched_reg;

endmodule

// File: rtl/fault_time_accumulator_debounce.sv
// Top level: elapsed-time stage, per-channel accumulator lanes and result register.
// An item is registered in the elapsed-time stage, then its result with out_valid high.
// Throughput: one item per cycle unless out_ready stalls; the loop that sets it is each
// lane's add, clamp and compare of its accumulator, for all channels at once.
// Reset: accumulators, raised flags, latched codes and the previous tick clear to zero,
// every channel timeout returns to 1000, and both pipeline stages empty.
module fault_time_accumulator_debounce #(
    parameter int CHANNELS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fta_pkg::TICK_W-1:0]     now_tick,
    input  logic [fta_pkg::CODE_W-1:0]     code_ch0,
    input  logic [fta_pkg::CODE_W-1:0]     code_ch1,
    input  logic [fta_pkg::CODE_W-1:0]     code_ch2,
    input  logic [fta_pkg::CODE_W-1:0]     code_ch3,
    input  logic [fta_pkg::CODE_W-1:0]     code_ch4,
    input  logic [fta_pkg::CODE_W-1:0]     code_ch5,
    input  logic [fta_pkg::CODE_W-1:0]     code_ch6,
    input  logic [fta_pkg::CODE_W-1:0]     code_ch7,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           any_fired,
    output logic [fta_pkg::MAX_CH-1:0]     fired_mask,
    output logic [fta_pkg::MAX_CH-1:0]     raised_mask,
    output logic [fta_pkg::CODE_W-1:0]     latched_ch0,
    output logic [fta_pkg::CODE_W-1:0]     latched_ch1,
    output logic [fta_pkg::CODE_W-1:0]     latched_ch2,
    output logic [fta_pkg::CODE_W-1:0]     latched_ch3,
    output logic [fta_pkg::CODE_W-1:0]     latched_ch4,
    output logic [fta_pkg::CODE_W-1:0]     latched_ch5,
    output logic [fta_pkg::CODE_W-1:0]     latched_ch6,
    output logic [fta_pkg::CODE_W-1:0]     latched_ch7,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fta_pkg::TMO_W-1:0]      cfg_data
);
    import fta_pkg::*;

    logic [TMO_W-1:0]  timeout_reg [MAX_CH];
    logic [TICK_W-1:0] prev_tick_reg;
    logic              s1_valid_reg;
    logic [TICK_W-1:0] s1_elapsed_reg;
    logic [CODE_W-1:0] s1_code_reg [MAX_CH];

    logic [CODE_W-1:0] code_in [MAX_CH];
    logic [CODE_W-1:0] latched [MAX_CH];
    lane_res_t         res [MAX_CH];
    logic              in_acc;
    logic              out_free;
    logic              s1_move;

    assign code_in[0] = code_ch0;
    assign code_in[1] = code_ch1;
    assign code_in[2] = code_ch2;
    assign code_in[3] = code_ch3;
    assign code_in[4] = code_ch4;
    assign code_in[5] = code_ch5;
    assign code_in[6] = code_ch6;
    assign code_in[7] = code_ch7;

    assign out_free  = !out_valid || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CH; c++)
            begin
                timeout_reg[c] <= TIMEOUT_RESET;
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(MAX_CH)))
        begin
            timeout_reg[cfg_index[$clog2(MAX_CH)-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_tick_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                prev_tick_reg <= now_tick;
                s1_valid_reg  <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // elapsed time wraps modulo 2^32
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_elapsed_reg <= now_tick - prev_tick_reg;
            for (int c = 0; c < MAX_CH; c++)
            begin
                s1_code_reg[c] <= code_in[c];
            end
        end
    end

    for (genvar c = 0; c < MAX_CH; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_on
            fta_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .upd     (s1_move),
                .elapsed (s1_elapsed_reg),
                .code    (s1_code_reg[c]),
                .timeout (timeout_reg[c]),
                .res     (res[c])
            );
        end
        else
        begin : g_off
            assign res[c] = '0;
        end
    end

    fta_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_move),
        .out_ready   (out_ready),
        .res         (res),
        .out_valid   (out_valid),
        .any_fired   (any_fired),
        .fired_mask  (fired_mask),
        .raised_mask (raised_mask),
        .latched     (latched)
    );

    assign latched_ch0 = latched[0];
    assign latched_ch1 = latched[1];
    assign latched_ch2 = latched[2];
    assign latched_ch3 = latched[3];
    assign latched_ch4 = latched[4];
    assign latched_ch5 = latched[5];
    assign latched_ch6 = latched[6];
    assign latched_ch7 = latched[7];

    a_fired_raises: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((fired_mask & ~raised_mask) == '0))
        else $error("fired channel not raised");

    a_latched_needs_raise: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (latched_ch0 != '0)) |-> raised_mask[0])
        else $error("latched code on a channel that is not raised");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid && !out_ready))
        else $error("input stalled without a full pipeline");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result appeared without a staged item");

endmodule

// File: dv/tb_fault_time_accumulator_debounce.sv
// Self-checking testbench for the leaky-bucket fault debounce: directed table, then random passes.
module tb_fault_time_accumulator_debounce;
    timeunit 1ns;
    timeprecision 1ps;

    import fta_pkg::*;

    typedef logic [MAX_CH-1:0][CODE_W-1:0] code_vec_t;

    typedef struct packed {
        logic              any_fired;
        logic [MAX_CH-1:0] fired_mask;
        logic [MAX_CH-1:0] raised_mask;
        code_vec_t         latched;
    } pass_res_t;

    typedef enum logic {ROW_PASS, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [TMO_W-1:0]     reg_val;
        logic [TICK_W-1:0]    tick;
        code_vec_t            codes;
        bit                   typed;
        pass_res_t            want;
    } stim_row_t;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH4 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH5 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH6 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH7 = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO    = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI    = 4'd15;

    localparam logic [TMO_W-1:0] TMO_MAX      = 31'h7FFF_FFFF;
    localparam int               RAND_PHASES  = 6;
    localparam int               PHASE_ITEMS  = 150;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [TICK_W-1:0]    now_tick;
    logic [CODE_W-1:0]    code_ch0, code_ch1, code_ch2, code_ch3;
    logic [CODE_W-1:0]    code_ch4, code_ch5, code_ch6, code_ch7;
    logic                 out_valid;
    logic                 out_ready;
    logic                 any_fired;
    logic [MAX_CH-1:0]    fired_mask;
    logic [MAX_CH-1:0]    raised_mask;
    logic [CODE_W-1:0]    latched_ch0, latched_ch1, latched_ch2, latched_ch3;
    logic [CODE_W-1:0]    latched_ch4, latched_ch5, latched_ch6, latched_ch7;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TMO_W-1:0]     cfg_data;

    // debounce state mirrored on the testbench side
    logic [TMO_W-1:0]  timeout_q [MAX_CH];
    logic [TMO_W-1:0]  fault_acc [MAX_CH];
    logic              raised_q  [MAX_CH];
    logic [CODE_W-1:0] held_q    [MAX_CH];
    logic [TICK_W-1:0] last_tick;

    pass_res_t pending_results[$];
    stim_row_t stim_rows[$];
    int        mismatches = 0;

    fault_time_accumulator_debounce DUT (.*);

    always #2 clk = ~clk;

    task automatic advance_debounce(input logic [TICK_W-1:0] tick, input code_vec_t codes,
                                    output pass_res_t res);
        logic [TICK_W-1:0] span32;
        logic [63:0]       span;
        logic [63:0]       acc;
        logic [63:0]       lim;
        span32 = tick - last_tick;
        span = 64'(span32);
        res = '0;
        for (int c = 0; c < MAX_CH; c++) begin
            acc = 64'(fault_acc[c]);
            lim = 64'(timeout_q[c]);
            if (codes[c] != '0) begin
                acc = acc + span;
                if (acc > lim)
                    acc = lim;
            end else begin
                acc = (acc > span) ? acc - span : 64'd0;
            end
            fault_acc[c] = acc[TMO_W-1:0];
            if (acc >= lim) begin
                held_q[c] = codes[c];
                raised_q[c] = 1'b1;
                res.fired_mask[c] = 1'b1;
            end else if (acc <= lim / 2) begin
                raised_q[c] = 1'b0;
                held_q[c] = '0;
            end
            res.raised_mask[c] = raised_q[c];
            res.latched[c] = held_q[c];
        end
        res.any_fired = |res.fired_mask;
        last_tick = tick;
    endtask

    function automatic stim_row_t pass_row(input logic [TICK_W-1:0] tick, input code_vec_t codes);
        stim_row_t r;
        r = '{kind: ROW_PASS, reg_idx: '0, reg_val: '0, tick: tick, codes: codes,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t checked_row(input logic [TICK_W-1:0] tick,
                                              input code_vec_t codes, input logic any_f,
                                              input logic [MAX_CH-1:0] fired,
                                              input logic [MAX_CH-1:0] raised,
                                              input code_vec_t latched);
        stim_row_t r;
        r = pass_row(tick, codes);
        r.typed = 1'b1;
        r.want = '{any_fired: any_f, fired_mask: fired, raised_mask: raised, latched: latched};
        return r;
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [TMO_W-1:0] val);
        stim_row_t r;
        r = pass_row('0, '0);
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [TMO_W-1:0] pick_timeout(input int phase);
        int pick;
        pick = $urandom_range(0, 9);
        case (phase)
            0: return TMO_W'($urandom_range(1, 64));
            1: begin
                if (pick == 0)
                    return '0;
                else if (pick == 1)
                    return TMO_W'(1);
                else if (pick == 2)
                    return TMO_MAX;
                return TMO_W'($urandom_range(2, 300));
            end
            2: return TMO_W'($urandom_range(1, 5000));
            3: return (pick < 3) ? TMO_MAX : TMO_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
            4: return TMO_W'($urandom());
            default: return (pick < 5) ? TIMEOUT_RESET : TMO_W'($urandom_range(500, 1500));
        endcase
    endfunction

    task automatic send_pass(input logic [TICK_W-1:0] tick, input code_vec_t codes,
                             input bit typed, input pass_res_t typed_res);
        pass_res_t pred;
        in_valid <= 1'b1;
        now_tick <= tick;
        code_ch0 <= codes[0];
        code_ch1 <= codes[1];
        code_ch2 <= codes[2];
        code_ch3 <= codes[3];
        code_ch4 <= codes[4];
        code_ch5 <= codes[5];
        code_ch6 <= codes[6];
        code_ch7 <= codes[7];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_debounce(tick, codes, pred);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // Keeps cfg_valid high; the caller drops it after the last write of a batch.
    task automatic write_timeout(input logic [CFG_IDX_W-1:0] idx, input logic [TMO_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < MAX_CH)
            timeout_q[idx[$clog2(MAX_CH)-1:0]] = val;
    endtask

    task automatic send_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            gap = 0;
        else if (pick < 80)
            gap = $urandom_range(1, 3);
        else if (pick < 96)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every pending result, then let the pipeline go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        $display("%0t ns: %s expected %h got %h", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk) begin : result_check
        pass_res_t want;
        code_vec_t got_latched;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
            got_latched = {latched_ch7, latched_ch6, latched_ch5, latched_ch4,
                           latched_ch3, latched_ch2, latched_ch1, latched_ch0};
            if (pending_results.size() == 0) begin
                $display("%0t ns: result arrived with nothing pending", $time);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (want.any_fired !== any_fired)
                    flag_mismatch("any_fired", 32'(want.any_fired), 32'(any_fired));
                if (want.fired_mask !== fired_mask)
                    flag_mismatch("fired_mask", 32'(want.fired_mask), 32'(fired_mask));
                if (want.raised_mask !== raised_mask)
                    flag_mismatch("raised_mask", 32'(want.raised_mask), 32'(raised_mask));
                for (int c = 0; c < MAX_CH; c++)
                    if (want.latched[c] !== got_latched[c])
                        flag_mismatch($sformatf("latched_ch%0d", c), 32'(want.latched[c]),
                                      32'(got_latched[c]));
            end
        end
    end

    // Result side: mostly ready, short stalls, now and then a long one.
    initial begin : result_sink
        int hold;
        int pick;
        out_ready = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    out_ready <= 1'b1;
                    hold = $urandom_range(1, 24);
                end else if (pick < 90) begin
                    out_ready <= 1'b0;
                    hold = $urandom_range(1, 3);
                end else begin
                    out_ready <= 1'b0;
                    hold = $urandom_range(8, 40);
                end
            end else begin
                hold--;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("watchdog expired, %0d results still pending", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [TICK_W-1:0] tick_at;
        logic [TICK_W-1:0] step;
        logic [TICK_W-1:0] lim;
        code_vec_t         codes;
        bit                fault_on [MAX_CH];
        logic [CODE_W-1:0] fault_code [MAX_CH];
        bit                burst;
        int                pick;
        int                ch;

        rst_n = 1'b0;
        in_valid = 1'b0;
        now_tick = '0;
        {code_ch0, code_ch1, code_ch2, code_ch3} = '0;
        {code_ch4, code_ch5, code_ch6, code_ch7} = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int c = 0; c < MAX_CH; c++) begin
            timeout_q[c] = TIMEOUT_RESET;
            fault_acc[c] = '0;
            raised_q[c] = 1'b0;
            held_q[c] = '0;
            fault_on[c] = 1'b0;
            fault_code[c] = '0;
        end
        last_tick = '0;

        // codes are listed ch7 first, ch0 last
        // first pass after reset: elapsed is the tick itself, here zero
        stim_rows.push_back(checked_row(32'd0, '0, 1'b0, 8'h00, 8'h00, '0));
        // half the timeout while faulty still sits at the clear threshold
        stim_rows.push_back(checked_row(32'd500, {8{16'hFFFF}}, 1'b0, 8'h00, 8'h00, '0));
        stim_rows.push_back(checked_row(32'd1000,
            {16'h5A5A, 16'hFFFF, 16'h8000, 16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001},
            1'b1, 8'hFF, 8'hFF,
            {16'h5A5A, 16'hFFFF, 16'h8000, 16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001}));
        // no time elapsed while healthy: fire again and latch zero
        stim_rows.push_back(checked_row(32'd1000, '0, 1'b1, 8'hFF, 8'hFF, '0));
        // between thresholds: hold the flag
        stim_rows.push_back(checked_row(32'd1250, '0, 1'b0, 8'h00, 8'hFF, '0));
        stim_rows.push_back(checked_row(32'd1750, '0, 1'b0, 8'h00, 8'h00, '0));
        stim_rows.push_back(checked_row(32'hFFFF_FF00, {8{16'h0001}}, 1'b1, 8'hFF, 8'hFF,
                                        {8{16'h0001}}));
        // tick wraps through zero
        stim_rows.push_back(pass_row(32'h0000_0010, '0));
        stim_rows.push_back(pass_row(32'h0000_0200,
            {16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hC3C3}));
        // zero timeout, smallest timeouts, the largest one, timeouts below the accumulator
        stim_rows.push_back(write_row(REG_TIMEOUT_CH0, '0));
        stim_rows.push_back(write_row(REG_TIMEOUT_CH1, 31'd1));
        stim_rows.push_back(write_row(REG_TIMEOUT_CH2, 31'd2));
        stim_rows.push_back(write_row(REG_TIMEOUT_CH3, TMO_MAX));
        stim_rows.push_back(write_row(REG_TIMEOUT_CH4, 31'd3));
        stim_rows.push_back(write_row(REG_TIMEOUT_CH5, 31'd1000));
        stim_rows.push_back(write_row(REG_TIMEOUT_CH6, 31'h4000_0000));
        stim_rows.push_back(write_row(REG_TIMEOUT_CH7, 31'h2AAA_AAAA));
        // out-of-range indexes must be ignored
        stim_rows.push_back(write_row(REG_SPARE_LO, 31'd5));
        stim_rows.push_back(write_row(REG_SPARE_HI, TMO_MAX));
        stim_rows.push_back(pass_row(32'h0000_0200,
            {16'h7777, 16'h0, 16'hABCD, 16'h0, 16'hFFFF, 16'h0, 16'h1234, 16'h0}));
        stim_rows.push_back(pass_row(32'h0000_0210,
            {16'h0001, 16'h8000, 16'h0, 16'h00FF, 16'h0, 16'hFF00, 16'h0, 16'h0001}));
        // elapsed of 2^31 clamps every faulty channel to its timeout
        stim_rows.push_back(checked_row(32'h8000_0210, {8{16'hFFFF}}, 1'b1, 8'hFF, 8'hFF,
                                        {8{16'hFFFF}}));
        stim_rows.push_back(pass_row(32'hC000_020F, '0));
        stim_rows.push_back(pass_row(32'hC000_0210, '0));
        stim_rows.push_back(pass_row(32'hFFFF_FFFF, {8{16'hFFFF}}));
        stim_rows.push_back(pass_row(32'h0000_0000, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                if (i == 0 || stim_rows[i-1].kind != ROW_WRITE)
                    settle();
                write_timeout(stim_rows[i].reg_idx, stim_rows[i].reg_val);
                if (i == stim_rows.size() - 1 || stim_rows[i+1].kind != ROW_WRITE)
                    cfg_valid <= 1'b0;
            end else begin
                send_pass(stim_rows[i].tick, stim_rows[i].codes, stim_rows[i].typed,
                          stim_rows[i].want);
                send_gap();
            end
        end
        tick_at = stim_rows[stim_rows.size() - 1].tick;

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle();
            for (int c = 0; c < MAX_CH; c++)
                write_timeout(REG_TIMEOUT_CH0 + CFG_IDX_W'(c), pick_timeout(phase));
            write_timeout(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                          TMO_W'($urandom()));
            cfg_valid <= 1'b0;
            burst = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                if (n == PHASE_ITEMS / 2)
                    settle();

                // step the tick on the scale of one channel's timeout
                ch = $urandom_range(0, MAX_CH - 1);
                lim = TICK_W'(timeout_q[ch]);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    step = '0;
                else if (pick < 80)
                    step = $urandom_range(0, lim / 2 + 1);
                else if (pick < 95)
                    step = $urandom_range(0, lim + lim / 4 + 2);
                else
                    step = $urandom();
                tick_at = tick_at + step;

                if ($urandom_range(0, 99) < 5) begin
                    for (int c = 0; c < MAX_CH; c++)
                        codes[c] = CODE_W'($urandom());
                end else begin
                    for (int c = 0; c < MAX_CH; c++) begin
                        if ($urandom_range(0, 99) < 12) begin
                            fault_on[c] = !fault_on[c];
                            fault_code[c] = CODE_W'($urandom_range(1, 16'hFFFF));
                        end else if (fault_on[c] && $urandom_range(0, 9) == 0) begin
                            fault_code[c] = CODE_W'($urandom_range(1, 16'hFFFF));
                        end
                        codes[c] = fault_on[c] ? fault_code[c] : '0;
                    end
                end

                send_pass(tick_at, codes, 1'b0, '0);
                if (!burst)
                    send_gap();
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/fta_pkg.sv
rtl/fta_lane.sv
rtl/fta_merge.sv
rtl/fault_time_accumulator_debounce.sv
dv/tb_fault_time_accumulator_debounce.sv
